FILE: src/point_in_region_classifier_unit_assert.svh
// Assertion macros shared by the point-in-region classifier RTL.
`ifndef POINT_IN_REGION_CLASSIFIER_UNIT_ASSERT_SVH
`define POINT_IN_REGION_CLASSIFIER_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PIRC_ASSERT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("pirc assertion failed");

// Next-cycle implication, checked outside reset.
`define PIRC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("pirc assertion failed");

`endif

FILE: src/pirc_pkg.sv
// Types, widths and codes of the point-in-region classifier.
package pirc_pkg;

    localparam int MAX_SHAPES = 64;
    localparam int COORD_BITS = 16;
    localparam int SLOT_W     = $clog2(MAX_SHAPES);
    localparam int COUNT_W    = 7;
    localparam int CFG_DATA_W = 7;
    localparam int NUM_C      = 6;

    localparam int DIFF_W  = COORD_BITS + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int AREA_W  = PROD_W + 1;
    localparam int SUM_W   = AREA_W + 2;
    localparam int N_OPS   = 8;
    localparam int N_AREAS = N_OPS / 2;

    localparam int S_FIELDS_W = 6 + (NUM_C + 2) * COORD_BITS;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = 1 + 2 * COORD_BITS;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef enum logic {
        KIND_LOAD  = 1'b0,
        KIND_QUERY = 1'b1
    } kind_t;

    typedef enum logic {
        MODE_RECT = 1'b0,
        MODE_TRI  = 1'b1
    } mode_t;

    typedef enum logic {
        REG_SHAPE_MODE  = 1'b0,
        REG_SHAPE_COUNT = 1'b1
    } reg_index_t;

    typedef struct packed {
        mode_t              mode;
        logic [COUNT_W-1:0] count;
    } cfg_t;

    typedef struct packed {
        logic                    valid;
        kind_t                   kind;
        logic [SLOT_W-1:0]       slot;
        coord_t [NUM_C-1:0]      c;
        coord_t                  px;
        coord_t                  py;
        logic                    last;
        logic                    hit;
    } item_t;

endpackage

FILE: src/pirc_cell.sv
// One shape cell: holds a shape, tests passing points and hands words on.
module pirc_cell (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic [pirc_pkg::SLOT_W-1:0]   cell_index,
    input  pirc_pkg::cfg_t                cfg,
    input  pirc_pkg::item_t               in_item,
    output pirc_pkg::item_t               out_item
);
    import pirc_pkg::*;

    coord_t sx_reg [3];
    coord_t sy_reg [3];

    logic signed [DIFF_W-1:0] opa_next [N_OPS];
    logic signed [DIFF_W-1:0] opb_next [N_OPS];
    logic signed [DIFF_W-1:0] opa_reg  [N_OPS];
    logic signed [DIFF_W-1:0] opb_reg  [N_OPS];
    logic signed [PROD_W-1:0] prod_next [N_OPS];
    logic signed [PROD_W-1:0] prod_reg  [N_OPS];
    logic signed [AREA_W-1:0] sarea_next [N_AREAS];
    logic [AREA_W-1:0]        area_next [N_AREAS];
    logic [AREA_W-1:0]        area_reg  [N_AREAS];
    logic [SUM_W-1:0]         sum_next;

    logic  shape_on;
    logic  in_rect;
    logic  rect_b_next, tri_b_next;
    logic  rect_b_reg, tri_b_reg, rect_c_reg, tri_c_reg, rect_d_reg, tri_d_reg;
    logic  shape_hit;
    item_t b_item_reg, c_item_reg, d_item_reg, out_reg, out_next;

    always_ff @(posedge aclk) begin
        if (en && in_item.valid && in_item.kind == KIND_LOAD && in_item.slot == cell_index) begin
            sx_reg[0] <= in_item.c[0];
            sy_reg[0] <= in_item.c[1];
            sx_reg[1] <= in_item.c[2];
            sy_reg[1] <= in_item.c[3];
            sx_reg[2] <= in_item.c[4];
            sy_reg[2] <= in_item.c[5];
        end
    end

    always_comb begin
        shape_on = COUNT_W'(cell_index) < cfg.count;
        in_rect  = in_item.px >= sx_reg[0] && in_item.px <= sx_reg[1] &&
                   in_item.py >= sy_reg[0] && in_item.py <= sy_reg[1];
        rect_b_next = shape_on && cfg.mode == MODE_RECT && in_rect;
        tri_b_next  = shape_on && cfg.mode == MODE_TRI;

        // Whole triangle, then the sub-triangles with the point replacing
        // the first, second and third vertex.
        opa_next[0] = DIFF_W'(sx_reg[1]) - DIFF_W'(sx_reg[0]);
        opb_next[0] = DIFF_W'(sy_reg[2]) - DIFF_W'(sy_reg[0]);
        opa_next[1] = DIFF_W'(sy_reg[1]) - DIFF_W'(sy_reg[0]);
        opb_next[1] = DIFF_W'(sx_reg[2]) - DIFF_W'(sx_reg[0]);
        opa_next[2] = DIFF_W'(sx_reg[1]) - DIFF_W'(in_item.px);
        opb_next[2] = DIFF_W'(sy_reg[2]) - DIFF_W'(in_item.py);
        opa_next[3] = DIFF_W'(sy_reg[1]) - DIFF_W'(in_item.py);
        opb_next[3] = DIFF_W'(sx_reg[2]) - DIFF_W'(in_item.px);
        opa_next[4] = DIFF_W'(in_item.px) - DIFF_W'(sx_reg[0]);
        opb_next[4] = DIFF_W'(sy_reg[2]) - DIFF_W'(sy_reg[0]);
        opa_next[5] = DIFF_W'(in_item.py) - DIFF_W'(sy_reg[0]);
        opb_next[5] = DIFF_W'(sx_reg[2]) - DIFF_W'(sx_reg[0]);
        opa_next[6] = DIFF_W'(sx_reg[1]) - DIFF_W'(sx_reg[0]);
        opb_next[6] = DIFF_W'(in_item.py) - DIFF_W'(sy_reg[0]);
        opa_next[7] = DIFF_W'(sy_reg[1]) - DIFF_W'(sy_reg[0]);
        opb_next[7] = DIFF_W'(in_item.px) - DIFF_W'(sx_reg[0]);

        for (int k = 0; k < N_OPS; k++) begin
            prod_next[k] = PROD_W'(opa_reg[k]) * PROD_W'(opb_reg[k]);
        end

        for (int j = 0; j < N_AREAS; j++) begin
            sarea_next[j] = AREA_W'(prod_reg[2*j]) - AREA_W'(prod_reg[2*j+1]);
            area_next[j]  = sarea_next[j][AREA_W-1] ? AREA_W'(-sarea_next[j])
                                                    : AREA_W'(sarea_next[j]);
        end

        sum_next  = SUM_W'(area_reg[1]) + SUM_W'(area_reg[2]) + SUM_W'(area_reg[3]);
        shape_hit = rect_d_reg ||
                    (tri_d_reg && area_reg[0] != '0 && sum_next <= SUM_W'(area_reg[0]));

        out_next     = d_item_reg;
        out_next.hit = d_item_reg.hit | shape_hit;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_item_reg.valid <= 1'b0;
            c_item_reg.valid <= 1'b0;
            d_item_reg.valid <= 1'b0;
            out_reg.valid    <= 1'b0;
        end else if (en) begin
            b_item_reg <= in_item;
            c_item_reg <= b_item_reg;
            d_item_reg <= c_item_reg;
            out_reg    <= out_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            opa_reg    <= opa_next;
            opb_reg    <= opb_next;
            prod_reg   <= prod_next;
            area_reg   <= area_next;
            rect_b_reg <= rect_b_next;
            tri_b_reg  <= tri_b_next;
            rect_c_reg <= rect_b_reg;
            tri_c_reg  <= tri_b_reg;
            rect_d_reg <= rect_c_reg;
            tri_d_reg  <= tri_c_reg;
        end
    end

    assign out_item = out_reg;

endmodule

FILE: src/point_in_region_classifier_unit.sv
// Point-in-region classifier: a row of shape cells, one per table slot.
//
// Input words arrive on s_tvalid/s_tready/s_tdata with s_tuser as the kind
// (load a shape or query a point) and s_tlast as the batch end marker.
// Load words write a shape into its slot and give no result. Each query word
// gives one result word on m_*: m_tdata carries the inside flag and the point,
// m_tlast copies the batch marker. Configuration writes through cfg_wr_en,
// cfg_index and cfg_data; the user must write it between batches only, as
// the block itself does not enforce it. Every word walks through all 64 cells,
// four register stages per cell, then the output register. One word is taken
// each cycle while s_tready is high; the row sets latency, not throughput.
// Loads and queries keep their order, so a query sees exactly the loads ahead.
// Reset empties the row and the output register and clears the configuration;
// shape slots stay undefined until loaded. No clearing pass is needed.
// While the receiver stalls with a result waiting, the row still advances
// until a query reaches its end; then s_tready drops until the word is taken.
`include "point_in_region_classifier_unit_assert.svh"

module point_in_region_classifier_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic                              cfg_index,
    input  logic [pirc_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // slot, c0, c1, c2, c3, c4, c5, px, py, then zero fill
    input  logic [pirc_pkg::S_TDATA_W-1:0]    s_tdata,
    // kind
    input  logic                              s_tuser,
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // inside_res, point_x, point_y, then zero fill
    output logic [pirc_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                              m_tlast
);
    import pirc_pkg::*;

    cfg_t   cfg_reg;
    item_t  chain [MAX_SHAPES+1];
    logic   advance;
    logic   last_q;
    logic   m_load;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   m_inside_reg;
    coord_t m_px_reg, m_py_reg;
    logic   m_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mode  <= MODE_RECT;
            cfg_reg.count <= '0;
        end else if (cfg_wr_en) begin
            unique case (reg_index_t'(cfg_index))
                REG_SHAPE_MODE:  cfg_reg.mode  <= mode_t'(cfg_data[0]);
                REG_SHAPE_COUNT: cfg_reg.count <= cfg_data[COUNT_W-1:0];
                default:         cfg_reg       <= cfg_reg;
            endcase
        end
    end

    always_comb begin
        chain[0].valid = s_tvalid;
        chain[0].kind  = kind_t'(s_tuser);
        chain[0].slot  = s_tdata[SLOT_W-1:0];
        for (int k = 0; k < NUM_C; k++) begin
            chain[0].c[k] = s_tdata[SLOT_W + k*COORD_BITS +: COORD_BITS];
        end
        chain[0].px   = s_tdata[SLOT_W + NUM_C*COORD_BITS +: COORD_BITS];
        chain[0].py   = s_tdata[SLOT_W + (NUM_C+1)*COORD_BITS +: COORD_BITS];
        chain[0].last = s_tlast;
        chain[0].hit  = 1'b0;
    end

    for (genvar i = 0; i < MAX_SHAPES; i++) begin : g_cell
        pirc_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .en         (advance),
            .cell_index (SLOT_W'(i)),
            .cfg        (cfg_reg),
            .in_item    (chain[i]),
            .out_item   (chain[i+1])
        );
    end

    assign last_q  = chain[MAX_SHAPES].valid && chain[MAX_SHAPES].kind == KIND_QUERY;
    assign advance = !(last_q && m_tvalid_reg && !m_tready);
    assign m_load  = (m_tready || !m_tvalid_reg) && last_q;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (m_tready || !m_tvalid_reg) begin
            m_tvalid_next = last_q;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_load) begin
            m_inside_reg <= chain[MAX_SHAPES].hit;
            m_px_reg     <= chain[MAX_SHAPES].px;
            m_py_reg     <= chain[MAX_SHAPES].py;
            m_last_reg   <= chain[MAX_SHAPES].last;
        end
    end

    assign s_tready = advance;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'({m_py_reg, m_px_reg, m_inside_reg});
    assign m_tlast  = m_last_reg;

    `PIRC_ASSERT(a_ready_when_out_free, !m_tvalid_reg, s_tready)
    `PIRC_ASSERT(a_result_from_row, $rose(m_tvalid_reg), $past(last_q))
    `PIRC_ASSERT_NEXT(a_blocked_query_holds, last_q && m_tvalid_reg && !m_tready, last_q)

endmodule
